@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.

package deq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // execute the accepted transaction this cycle
        logic respond;  // present the result of the last transaction
    } t_dp_cmd;

    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

endpackage

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on deq_pkg, deq_ctrl, deq_datapath and deq_ram.

// Each transaction is accepted at a rising edge where start is high and busy
// is low, and its result appears on the o_ ports during the following cycle,
// marked by o_done, while busy is high. The response cycle is set by the
// registered read port of the entry RAM, which a pop must wait on. The
// receiver cannot stall: o_done is high for exactly one cycle and the result
// is gone after it, so capture it then. A new transaction can be started in
// the cycle after o_done; none is accepted while busy is high.
//
// Commands are push front, push back, pop front and pop back. A pop returns the
// removed value with status done; a pop on an empty queue returns -1 with
// status empty and leaves the queue untouched. A push returns value 0; a push
// on a full queue is dropped and reports status full. The occupancy port gives
// the number of entries held after the transaction, taken modulo 32.
//
// The entries live in a circular buffer of DEPTH words with a front index, a
// back index and an entry count, all cleared by reset. The buffer itself needs
// no clearing, since only entries that were written can ever be popped.

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_push_value,
    output logic        o_done,
    output logic [31:0] o_pop_value,
    output logic [1:0]  o_status,
    output logic [4:0]  o_occupancy
);

    deq_pkg::t_dp_cmd dp_cmd;

    // The controller sequences accept and respond; it never looks at the data.
    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd)
    );

    // The datapath executes the command in the accept cycle (indices, count,
    // RAM write or read) and holds the result for the response cycle.
    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_done       (o_done),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

@@ rtl/deq_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the double-ended queue: accepts a transaction, then presents its result.
// Depends on deq_pkg.

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output deq_pkg::t_dp_cmd o_dp_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_busy           = 1'b0;
        o_dp_cmd.load    = 1'b0;
        o_dp_cmd.respond = 1'b0;
        unique case (r_state)
            deq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = deq_pkg::ST_RESP;
                end
            end
            deq_pkg::ST_RESP: begin
                o_busy           = 1'b1;
                o_dp_cmd.respond = 1'b1;
                n_state          = deq_pkg::ST_IDLE;
            end
            default: begin
                n_state = deq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/deq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the double-ended queue: circular buffer, front/back indices and entry count.
// Depends on deq_pkg and deq_ram.

module deq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  deq_pkg::t_dp_cmd i_dp_cmd,
    input  logic [1:0]       i_command,
    input  logic [31:0]      i_push_value,
    output logic             o_done,
    output logic [31:0]      o_pop_value,
    output logic [1:0]       o_status,
    output logic [4:0]       o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [AW-1:0]   r_front;
    logic [AW-1:0]   n_front;
    logic [AW-1:0]   r_back;
    logic [AW-1:0]   n_back;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    deq_pkg::t_status r_status;
    deq_pkg::t_status n_status;
    logic            r_from_ram;
    logic            n_from_ram;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] back_dec;
    logic [AW-1:0] back_inc;
    logic          is_full;
    logic          is_empty;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [CW+4:0] count_ext;

    // Wrapping index arithmetic; DEPTH need not be a power of two.
    assign front_dec = (r_front == '0) ? LAST_INDEX : r_front - AW'(1);
    assign front_inc = (r_front == LAST_INDEX) ? '0 : r_front + AW'(1);
    assign back_dec  = (r_back == '0) ? LAST_INDEX : r_back - AW'(1);
    assign back_inc  = (r_back == LAST_INDEX) ? '0 : r_back + AW'(1);
    assign is_full   = (r_count == FULL_COUNT);
    assign is_empty  = (r_count == '0);

    always_comb begin
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_status   = r_status;
        n_from_ram = r_from_ram;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_back;
        ram_raddr  = r_front;
        if (i_dp_cmd.load) begin
            n_status   = deq_pkg::STAT_DONE;
            n_from_ram = 1'b0;
            unique case (deq_pkg::t_cmd'(i_command))
                deq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = deq_pkg::STAT_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = front_dec;
                        n_front   = front_dec;
                        n_count   = r_count + CW'(1);
                    end
                end
                deq_pkg::CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = deq_pkg::STAT_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_back;
                        n_back    = back_inc;
                        n_count   = r_count + CW'(1);
                    end
                end
                deq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = deq_pkg::STAT_EMPTY;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = r_front;
                        n_from_ram = 1'b1;
                        n_front    = front_inc;
                        n_count    = r_count - CW'(1);
                    end
                end
                deq_pkg::CMD_POP_BACK: begin
                    if (is_empty) begin
                        n_status = deq_pkg::STAT_EMPTY;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = back_dec;
                        n_from_ram = 1'b1;
                        n_back     = back_dec;
                        n_count    = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = deq_pkg::STAT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_back     <= '0;
            r_count    <= '0;
            r_status   <= deq_pkg::STAT_DONE;
            r_from_ram <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_back     <= n_back;
            r_count    <= n_count;
            r_status   <= n_status;
            r_from_ram <= n_from_ram;
        end
    end

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The occupancy port is five bits wide whatever the depth.
    assign count_ext   = {5'd0, r_count};
    assign o_occupancy = count_ext[4:0];
    assign o_status    = r_status;
    assign o_done      = i_dp_cmd.respond;

    always_comb begin
        if (r_from_ram) begin
            o_pop_value = ram_rdata;
        end else if (r_status == deq_pkg::STAT_EMPTY) begin
            o_pop_value = deq_pkg::EMPTY_VALUE;
        end else begin
            o_pop_value = '0;
        end
    end

endmodule
